/* src/pls_pkg.sv */
package pls_pkg;

    localparam int SEGMENT_DEPTH_DEF = 64;
    localparam int SMP_W             = 16;
    localparam int IDX_W             = 6;
    localparam int CFG_IDX_W         = 1;
    localparam int CFG_W             = 16;
    localparam int CHUNK_W           = 16;

    localparam logic [CFG_IDX_W-1:0] REG_SPACING = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EPSILON = 1'd1;

    localparam logic [CFG_W-1:0] SPACING_RST = 16'd256;
    localparam logic [CFG_W-1:0] EPSILON_RST = 16'd1;

    typedef struct packed {
        logic store_wr;
        logic seg_init;
        logic push_init;
        logic pop;
        logic rng_latch;
        logic ya_latch;
        logic ye_latch;
        logic len_step1;
        logic len_step2;
        logic pt_rd;
        logic pt_mul;
        logic pt_cmp;
        logic mul_step;
        logic mul_sel_t;
        logic mark_best;
        logic push_hi;
        logic push_lo;
        logic emit_clr;
        logic emit_rd;
        logic emit_next;
        logic seg_done;
    } pls_cmd_t;

    typedef struct packed {
        logic sp_empty;
        logic n_small;
        logic short_rng;
        logic pt_last;
        logic mul_last;
        logic split;
        logic room;
        logic emit_end;
        logic emit_kept;
    } pls_status_t;

endpackage

/* src/pls_ctrl.sv */
module pls_ctrl
    import pls_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        is_last,
    input  logic        out_ready,
    output logic        in_ready,
    output logic        out_valid,
    output pls_cmd_t    cmd,
    input  pls_status_t status
);

    typedef enum logic [16:0] {
        S_IDLE     = 17'b00000000000000001,
        S_INIT     = 17'b00000000000000010,
        S_POP      = 17'b00000000000000100,
        S_RNG      = 17'b00000000000001000,
        S_YA       = 17'b00000000000010000,
        S_YE       = 17'b00000000000100000,
        S_LEN1     = 17'b00000000001000000,
        S_LEN2     = 17'b00000000010000000,
        S_PT_RD    = 17'b00000000100000000,
        S_PT_MUL   = 17'b00000001000000000,
        S_PT_CMP   = 17'b00000010000000000,
        S_MUL_C    = 17'b00000100000000000,
        S_MUL_T    = 17'b00001000000000000,
        S_DECIDE   = 17'b00010000000000000,
        S_PUSH2    = 17'b00100000000000000,
        S_EMIT_RD  = 17'b01000000000000000,
        S_EMIT_OUT = 17'b10000000000000000
    } state_t;

    state_t state_reg, state_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_EMIT_OUT);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.store_wr = 1'b1;
                    if (is_last)
                    begin
                        state_next = S_INIT;
                    end
                end
            end
            S_INIT:
            begin
                cmd.seg_init  = 1'b1;
                cmd.push_init = !status.n_small;
                state_next    = S_POP;
            end
            S_POP:
            begin
                if (status.sp_empty)
                begin
                    cmd.emit_clr = 1'b1;
                    state_next   = S_EMIT_RD;
                end
                else
                begin
                    cmd.pop    = 1'b1;
                    state_next = S_RNG;
                end
            end
            S_RNG:
            begin
                cmd.rng_latch = 1'b1;
                state_next    = status.short_rng ? S_POP : S_YA;
            end
            S_YA:
            begin
                cmd.ya_latch = 1'b1;
                state_next   = S_YE;
            end
            S_YE:
            begin
                cmd.ye_latch = 1'b1;
                state_next   = S_LEN1;
            end
            S_LEN1:
            begin
                cmd.len_step1 = 1'b1;
                state_next    = S_LEN2;
            end
            S_LEN2:
            begin
                cmd.len_step2 = 1'b1;
                state_next    = S_PT_RD;
            end
            S_PT_RD:
            begin
                cmd.pt_rd  = 1'b1;
                state_next = S_PT_MUL;
            end
            S_PT_MUL:
            begin
                cmd.pt_mul = 1'b1;
                state_next = S_PT_CMP;
            end
            S_PT_CMP:
            begin
                cmd.pt_cmp = 1'b1;
                state_next = status.pt_last ? S_MUL_C : S_PT_RD;
            end
            S_MUL_C:
            begin
                cmd.mul_step = 1'b1;
                if (status.mul_last)
                begin
                    state_next = S_MUL_T;
                end
            end
            S_MUL_T:
            begin
                cmd.mul_step  = 1'b1;
                cmd.mul_sel_t = 1'b1;
                if (status.mul_last)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                state_next = S_POP;
                if (status.split)
                begin
                    cmd.mark_best = 1'b1;
                    if (status.room)
                    begin
                        cmd.push_hi = 1'b1;
                        state_next  = S_PUSH2;
                    end
                end
            end
            S_PUSH2:
            begin
                cmd.push_lo = 1'b1;
                state_next  = S_POP;
            end
            S_EMIT_RD:
            begin
                if (status.emit_end)
                begin
                    cmd.seg_done = 1'b1;
                    state_next   = S_IDLE;
                end
                else if (status.emit_kept)
                begin
                    cmd.emit_rd = 1'b1;
                    state_next  = S_EMIT_OUT;
                end
                else
                begin
                    cmd.emit_next = 1'b1;
                end
            end
            S_EMIT_OUT:
            begin
                if (out_ready)
                begin
                    cmd.emit_next = 1'b1;
                    state_next    = S_EMIT_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* src/pls_dp.sv */
module pls_dp
    import pls_pkg::*;
#(
    parameter int SEGMENT_DEPTH = SEGMENT_DEPTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  pls_cmd_t             cmd,
    output pls_status_t          status,
    input  logic [SMP_W-1:0]     sample_value,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output logic [IDX_W-1:0]     kept_index,
    output logic [SMP_W-1:0]     kept_value,
    output logic                 final_point
);

    localparam int AW      = $clog2(SEGMENT_DEPTH);
    localparam int CNT_W   = $clog2(SEGMENT_DEPTH + 1);
    localparam int DX_W    = AW + CFG_W;
    localparam int DY_W    = SMP_W + 1;
    localparam int C_W     = DX_W + DY_W + 1;
    localparam int MAG_W   = C_W - 1;
    localparam int DY2_W   = 2 * SMP_W;
    localparam int DX2_W   = 2 * DX_W;
    localparam int EPS2_W  = 2 * CFG_W;
    localparam int HI_W    = DY2_W + CHUNK_W;
    localparam int LEN_W   = ((HI_W > DX2_W) ? HI_W : DX2_W) + 1;
    localparam int NCH     = (MAG_W > EPS2_W) ? (MAG_W + CHUNK_W - 1) / CHUNK_W
                                              : EPS2_W / CHUNK_W;
    localparam int OPB_W   = NCH * CHUNK_W;
    localparam int K_W     = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int PART_W  = LEN_W + CHUNK_W;
    localparam int ACC_W   = LEN_W + OPB_W;
    localparam int SH_W    = $clog2(ACC_W);

    // Configuration registers.
    logic [CFG_W-1:0] spacing_reg;
    logic [CFG_W-1:0] eps_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spacing_reg <= SPACING_RST;
            eps_reg     <= EPSILON_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_SPACING: spacing_reg <= cfg_data;
                REG_EPSILON: eps_reg     <= cfg_data;
                default:     ;
            endcase
        end
    end

    // Control counters and marks.
    logic [CNT_W-1:0]         fill_reg;
    logic [CNT_W-1:0]         sp_reg;
    logic [CNT_W-1:0]         i_reg;
    logic [SEGMENT_DEPTH-1:0] marks_reg;
    logic [K_W-1:0]           k_reg;
    logic                     k_last;
    logic                     fill_room;
    logic [AW-1:0]            last_idx;

    assign fill_room = (fill_reg < CNT_W'(SEGMENT_DEPTH));
    assign last_idx  = AW'(fill_reg - CNT_W'(1));
    assign k_last    = (k_reg == K_W'(NCH - 1));

    // Range registers.
    logic [2*AW-1:0]         stk_rd_reg;
    logic [AW-1:0]           b_reg;
    logic [AW-1:0]           e_reg;
    logic [AW-1:0]           p_reg;
    logic [AW-1:0]           bi_reg;
    logic [AW-1:0]           stk_b;
    logic [AW-1:0]           stk_e;

    assign stk_b = stk_rd_reg[2*AW-1:AW];
    assign stk_e = stk_rd_reg[AW-1:0];

    // Sample store and range stack.
    logic [SMP_W-1:0]  store_mem [SEGMENT_DEPTH];
    logic [2*AW-1:0]   stack_mem [SEGMENT_DEPTH];
    logic [SMP_W-1:0]  rd_data_reg;
    logic [AW-1:0]     rd_addr;
    logic              rd_en;
    logic              push_en;
    logic [2*AW-1:0]   push_data;

    always_comb
    begin
        rd_addr = i_reg[AW-1:0];
        if (cmd.rng_latch)
        begin
            rd_addr = stk_b;
        end
        else if (cmd.ya_latch)
        begin
            rd_addr = e_reg;
        end
        else if (cmd.pt_rd)
        begin
            rd_addr = p_reg;
        end
    end

    assign rd_en = cmd.rng_latch | cmd.ya_latch | cmd.pt_rd | cmd.emit_rd;

    always_comb
    begin
        push_data = {bi_reg, e_reg};
        if (cmd.push_init)
        begin
            push_data = {AW'(0), last_idx};
        end
        else if (cmd.push_lo)
        begin
            push_data = {b_reg, bi_reg};
        end
    end

    assign push_en = cmd.push_init | cmd.push_hi | cmd.push_lo;

    always_ff @(posedge clk)
    begin
        if (cmd.store_wr && fill_room)
        begin
            store_mem[fill_reg[AW-1:0]] <= sample_value;
        end
        if (rd_en)
        begin
            rd_data_reg <= store_mem[rd_addr];
        end
        if (push_en)
        begin
            stack_mem[sp_reg[AW-1:0]] <= push_data;
        end
        if (cmd.pop)
        begin
            stk_rd_reg <= stack_mem[AW'(sp_reg - CNT_W'(1))];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            sp_reg    <= '0;
            i_reg     <= '0;
            marks_reg <= '0;
            k_reg     <= '0;
        end
        else
        begin
            if (cmd.store_wr && fill_room)
            begin
                fill_reg <= fill_reg + CNT_W'(1);
            end
            else if (cmd.seg_done)
            begin
                fill_reg <= '0;
            end

            if (push_en)
            begin
                sp_reg <= sp_reg + CNT_W'(1);
            end
            else if (cmd.pop)
            begin
                sp_reg <= sp_reg - CNT_W'(1);
            end

            if (cmd.emit_clr)
            begin
                i_reg <= '0;
            end
            else if (cmd.emit_next)
            begin
                i_reg <= i_reg + CNT_W'(1);
            end

            if (cmd.seg_done)
            begin
                marks_reg <= '0;
            end
            else if (cmd.seg_init)
            begin
                // Both endpoints of the segment are always kept.
                marks_reg <= marks_reg | SEGMENT_DEPTH'(1)
                             | (SEGMENT_DEPTH'(1) << last_idx);
            end
            else if (cmd.mark_best)
            begin
                marks_reg[bi_reg] <= 1'b1;
            end

            if (cmd.mul_step)
            begin
                k_reg <= k_last ? '0 : k_reg + K_W'(1);
            end
        end
    end

    // Chord and distance arithmetic.
    logic signed [SMP_W-1:0]  ya_reg;
    logic signed [DY_W-1:0]   dy_reg;
    logic [DX_W-1:0]          dx_reg;
    logic [DX_W-1:0]          tp_reg;
    logic [DY2_W-1:0]         dy2_reg;
    logic [DX2_W-1:0]         dx2_reg;
    logic [EPS2_W-1:0]        eps2_reg;
    logic [LEN_W-1:0]         len_reg;
    logic signed [C_W-1:0]    prod1_reg;
    logic signed [C_W-1:0]    prod2_reg;
    logic [MAG_W-1:0]         best_reg;
    logic signed [DY_W-1:0]   ye_diff;
    logic signed [DY_W-1:0]   yp_diff;
    logic signed [2*DY_W-1:0] dy_sq;
    logic signed [C_W-1:0]    c_val;
    logic [C_W-1:0]           c_abs;
    logic [MAG_W-1:0]         mag;

    assign ye_diff = DY_W'($signed(rd_data_reg)) - DY_W'(ya_reg);
    assign yp_diff = ye_diff;
    assign dy_sq   = dy_reg * dy_reg;
    assign c_val   = prod1_reg - prod2_reg;
    assign c_abs   = c_val[C_W-1] ? C_W'(-c_val) : C_W'(c_val);
    assign mag     = c_abs[MAG_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.rng_latch)
        begin
            b_reg <= stk_b;
            e_reg <= stk_e;
        end
        if (cmd.ya_latch)
        begin
            ya_reg <= $signed(rd_data_reg);
        end
        if (cmd.ye_latch)
        begin
            dy_reg   <= ye_diff;
            dx_reg   <= AW'(e_reg - b_reg) * spacing_reg;
            p_reg    <= b_reg + AW'(1);
            bi_reg   <= b_reg + AW'(1);
            best_reg <= '0;
        end
        if (cmd.len_step1)
        begin
            dy2_reg  <= dy_sq[DY2_W-1:0];
            dx2_reg  <= dx_reg * dx_reg;
            eps2_reg <= eps_reg * eps_reg;
        end
        if (cmd.len_step2)
        begin
            len_reg <= LEN_W'({dy2_reg, CHUNK_W'(0)}) + LEN_W'(dx2_reg);
        end
        if (cmd.pt_rd)
        begin
            tp_reg <= AW'(p_reg - b_reg) * spacing_reg;
        end
        if (cmd.pt_mul)
        begin
            prod1_reg <= dy_reg * $signed({1'b0, tp_reg});
            prod2_reg <= $signed({1'b0, dx_reg}) * yp_diff;
        end
        if (cmd.pt_cmp)
        begin
            // Strict compare keeps the first of equally distant points.
            if (mag > best_reg)
            begin
                best_reg <= mag;
                bi_reg   <= p_reg;
            end
            p_reg <= p_reg + AW'(1);
        end
    end

    // Wide products are made one 16-bit chunk of the second operand per cycle.
    logic [LEN_W-1:0]  op_a;
    logic [OPB_W-1:0]  op_b;
    logic [CHUNK_W-1:0] chunk;
    logic [PART_W-1:0] part;
    logic [SH_W-1:0]   shamt;
    logic [ACC_W-1:0]  part_sh;
    logic [ACC_W-1:0]  acc_next;
    logic [ACC_W-1:0]  acc_reg;
    logic [ACC_W-1:0]  csq_reg;

    assign op_a     = cmd.mul_sel_t ? len_reg : LEN_W'(best_reg);
    assign op_b     = cmd.mul_sel_t ? OPB_W'(eps2_reg) : OPB_W'(best_reg);
    assign shamt    = SH_W'(k_reg) * SH_W'(CHUNK_W);
    assign chunk    = CHUNK_W'(op_b >> shamt);
    assign part     = op_a * chunk;
    assign part_sh  = ACC_W'(part) << shamt;
    assign acc_next = (k_reg == '0) ? part_sh : acc_reg + part_sh;

    always_ff @(posedge clk)
    begin
        if (cmd.mul_step)
        begin
            acc_reg <= acc_next;
            if (k_last && !cmd.mul_sel_t)
            begin
                csq_reg <= acc_next;
            end
        end
    end

    // Status back to the controller.
    assign status.sp_empty  = (sp_reg == '0);
    assign status.n_small   = (fill_reg < CNT_W'(3));
    assign status.short_rng = ({1'b0, stk_e} < ({1'b0, stk_b} + (AW + 1)'(2)));
    assign status.pt_last   = (({1'b0, p_reg} + (AW + 1)'(1)) == {1'b0, e_reg});
    assign status.mul_last  = k_last;
    assign status.split     = (csq_reg > acc_reg);
    assign status.room      = (({1'b0, sp_reg} + (CNT_W + 1)'(2))
                               <= (CNT_W + 1)'(SEGMENT_DEPTH));
    assign status.emit_end  = (i_reg == fill_reg);
    assign status.emit_kept = marks_reg[i_reg[AW-1:0]];

    assign kept_index  = IDX_W'(i_reg[AW-1:0]);
    assign kept_value  = rd_data_reg;
    assign final_point = (i_reg == (fill_reg - CNT_W'(1)));

endmodule

/* src/polyline_simplifier.sv */
// Samples load one per cycle while the block is idle; the sample flagged last starts simplification.
// Each range is popped from the stack, its chord is measured, every interior point's distance
// is compared to find the farthest, and the chunked multiplier performs the split test; a split
// marks that point and pushes both halves when the stack has room. Kept points then leave
// one at a time under the out_ready handshake, and dropped points are skipped.
// Reset is asynchronous, active low; it empties the segment and the range stack.
module polyline_simplifier
    import pls_pkg::*;
#(
    parameter int SEGMENT_DEPTH = SEGMENT_DEPTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [SMP_W-1:0]     sample_value,
    input  logic                 is_last,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [IDX_W-1:0]     kept_index,
    output logic [SMP_W-1:0]     kept_value,
    output logic                 final_point,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    pls_cmd_t    cmd;
    pls_status_t status;

    pls_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .is_last   (is_last),
        .out_ready (out_ready),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .cmd       (cmd),
        .status    (status)
    );

    pls_dp #(
        .SEGMENT_DEPTH (SEGMENT_DEPTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .sample_value (sample_value),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .kept_index   (kept_index),
        .kept_value   (kept_value),
        .final_point  (final_point)
    );

endmodule
